/* hdl/prs_pkg.sv */
// Shared types and constants for the polyline ribbon strip generator.
package prs_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam logic OPC_PUSH  = 1'b0;
    localparam logic OPC_CLEAR = 1'b1;

    localparam logic [1:0] REG_MAX_POINTS     = 2'd0;
    localparam logic [1:0] REG_HALF_THICKNESS = 2'd1;
    localparam logic [1:0] REG_FADE_POINTS    = 2'd2;
    localparam logic [1:0] REG_BASE_ALPHA     = 2'd3;

    localparam logic [4:0] NORM_LAST = 5'd5;
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd25;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_LD0, S_LD1, S_LDI, S_DIFF, S_NORM, S_SQ,
        S_SUM, S_SQRT, S_MUL, S_DIVLD, S_DIV, S_EMITL, S_EMITR, S_NEXT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_PUSH, OP_CLEAR, OP_INIT, OP_CAP_CUR, OP_CAP_NBR, OP_NEXT,
        OP_DIFF, OP_NORM, OP_SQ, OP_SUM, OP_SQRT, OP_MUL, OP_DIVLD, OP_DIV,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        RD_NONE, RD_AGE0, RD_AGE1, RD_NEXT
    } t_rd;

    typedef struct packed {
        t_op        op;
        t_rd        rd;
        logic [4:0] step;
        logic       side;
    } t_cmd;

    typedef struct packed {
        logic m_zero;
        logic few;
        logic last_pt;
        logic out_free;
    } t_stat;

endpackage

/* hdl/prs_ctrl.sv */
// Sequencer for the ribbon generator: walks each held point through the datapath.
module prs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_opcode,
    input  prs_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output prs_pkg::t_cmd  o_cmd
);

    prs_pkg::t_state r_state, n_state;
    logic [4:0]      r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prs_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = prs_pkg::OP_NONE;
        o_cmd.rd   = prs_pkg::RD_NONE;
        o_cmd.step = r_cnt;
        o_cmd.side = 1'b0;
        o_in_stall = (r_state != prs_pkg::S_IDLE);
        unique case (r_state)
            prs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == prs_pkg::OPC_CLEAR) begin
                        o_cmd.op = prs_pkg::OP_CLEAR;
                    end else begin
                        o_cmd.op = prs_pkg::OP_PUSH;
                        n_state  = prs_pkg::S_CHECK;
                    end
                end
            end
            prs_pkg::S_CHECK: begin
                if (i_stat.few) begin
                    n_state = prs_pkg::S_IDLE;
                end else begin
                    o_cmd.op = prs_pkg::OP_INIT;
                    o_cmd.rd = prs_pkg::RD_AGE0;
                    n_state  = prs_pkg::S_LD0;
                end
            end
            prs_pkg::S_LD0: begin
                o_cmd.op = prs_pkg::OP_CAP_CUR;
                o_cmd.rd = prs_pkg::RD_AGE1;
                n_state  = prs_pkg::S_LD1;
            end
            prs_pkg::S_LD1: begin
                o_cmd.op = prs_pkg::OP_CAP_NBR;
                n_state  = prs_pkg::S_DIFF;
            end
            prs_pkg::S_LDI: begin
                o_cmd.op = prs_pkg::OP_CAP_CUR;
                n_state  = prs_pkg::S_DIFF;
            end
            prs_pkg::S_DIFF: begin
                o_cmd.op = prs_pkg::OP_DIFF;
                n_cnt    = '0;
                n_state  = prs_pkg::S_NORM;
            end
            prs_pkg::S_NORM: begin
                o_cmd.op = prs_pkg::OP_NORM;
                if (r_cnt == '0 && i_stat.m_zero) begin
                    n_state = prs_pkg::S_MUL;
                end else if (r_cnt == prs_pkg::NORM_LAST) begin
                    n_state = prs_pkg::S_SQ;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            prs_pkg::S_SQ: begin
                o_cmd.op = prs_pkg::OP_SQ;
                n_state  = prs_pkg::S_SUM;
            end
            prs_pkg::S_SUM: begin
                o_cmd.op = prs_pkg::OP_SUM;
                n_cnt    = '0;
                n_state  = prs_pkg::S_SQRT;
            end
            prs_pkg::S_SQRT: begin
                o_cmd.op = prs_pkg::OP_SQRT;
                if (r_cnt == prs_pkg::SQRT_LAST) begin
                    n_state = prs_pkg::S_MUL;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            prs_pkg::S_MUL: begin
                o_cmd.op = prs_pkg::OP_MUL;
                n_state  = prs_pkg::S_DIVLD;
            end
            prs_pkg::S_DIVLD: begin
                o_cmd.op = prs_pkg::OP_DIVLD;
                n_cnt    = '0;
                n_state  = prs_pkg::S_DIV;
            end
            prs_pkg::S_DIV: begin
                o_cmd.op = prs_pkg::OP_DIV;
                if (r_cnt == prs_pkg::DIV_LAST) begin
                    n_state = prs_pkg::S_EMITL;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            prs_pkg::S_EMITL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = prs_pkg::OP_EMIT;
                    n_state  = prs_pkg::S_EMITR;
                end
            end
            prs_pkg::S_EMITR: begin
                o_cmd.side = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.op = prs_pkg::OP_EMIT;
                    n_state  = prs_pkg::S_NEXT;
                end
            end
            prs_pkg::S_NEXT: begin
                if (i_stat.last_pt) begin
                    n_state = prs_pkg::S_IDLE;
                end else begin
                    o_cmd.op = prs_pkg::OP_NEXT;
                    o_cmd.rd = prs_pkg::RD_NEXT;
                    n_state  = prs_pkg::S_LDI;
                end
            end
            default: n_state = prs_pkg::S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == prs_pkg::OP_EMIT |-> i_stat.out_free)
        else $error("vertex loaded while output busy");

    a_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == prs_pkg::S_NORM |-> r_cnt <= prs_pkg::NORM_LAST)
        else $error("normalize step overrun");

    a_right_after_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prs_pkg::S_EMITL && i_stat.out_free) |=> r_state == prs_pkg::S_EMITR)
        else $error("right vertex does not follow left");

endmodule

/* hdl/prs_dpath.sv */
// Datapath: point history, segment normalize, root and divide units, vertex register.
module prs_dpath #(
    parameter int MAX_POINTS = prs_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prs_pkg::t_cmd       i_cmd,
    input  logic [31:0]         i_point_x,
    input  logic [31:0]         i_point_y,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_out_stall,
    output prs_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    output logic signed [31:0]  o_vertex_x,
    output logic signed [31:0]  o_vertex_y,
    output logic                o_side,
    output logic [3:0]          o_point_index,
    output logic [7:0]          o_alpha,
    output logic                o_last
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = CW + 1;
    localparam logic [5:0] MAXP6 = 6'(MAX_POINTS);

    logic [63:0] mem [MAX_POINTS];
    logic [63:0] r_rd;

    logic [4:0]  r_max_points;
    logic [15:0] r_half;
    logic [4:0]  r_fade_points;
    logic [7:0]  r_base_alpha;

    logic [AW-1:0] r_newest;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;

    logic [31:0] r_cur_x, r_cur_y, r_nbr_x, r_nbr_y, r_prev_x, r_prev_y;
    logic [32:0] r_ax, r_ay;
    logic        r_dxp, r_dyp;
    logic [61:0] r_sqx, r_sqy;
    logic [63:0] r_v, r_root, r_bit;
    logic [54:0] r_nx, r_ny;
    logic [31:0] r_remx, r_remy;
    logic [25:0] r_qx, r_qy, r_qa;
    logic [4:0]  r_rema;

    logic        r_ovalid;
    logic [31:0] r_vx, r_vy;
    logic        r_side, r_last;
    logic [3:0]  r_pidx;
    logic [7:0]  r_alpha;

    // clamped configuration
    logic [5:0]    mp6, maxe6, fade6, start6, i6, k6;
    logic [CW-1:0] maxe;
    logic [4:0]    fade5;
    logic          faded;
    logic [13:0]   anum;

    always_comb begin
        mp6    = {1'b0, r_max_points};
        maxe6  = (mp6 < 6'd2) ? 6'd2 : ((mp6 > MAXP6) ? MAXP6 : mp6);
        maxe   = CW'(maxe6);
        fade6  = ({1'b0, r_fade_points} > maxe6) ? maxe6 : {1'b0, r_fade_points};
        fade5  = fade6[4:0];
        start6 = maxe6 - fade6;
        i6     = 6'(r_i);
        faded  = (fade6 != '0) && (i6 >= start6);
        k6     = maxe6 - i6;
        anum   = {k6, 8'h00} - {8'h00, k6};
    end

    // history addressing
    logic [AW-1:0] newest_inc, rd_addr;
    logic [CW-1:0] rd_age;
    logic [SW-1:0] ns, ag;
    logic [CW:0]   cnt_inc;
    logic [CW-1:0] cnt_next;

    always_comb begin
        newest_inc = (r_newest == AW'(MAX_POINTS - 1)) ? '0 : r_newest + 1'b1;
        case (i_cmd.rd)
            prs_pkg::RD_AGE1: rd_age = CW'(1);
            prs_pkg::RD_NEXT: rd_age = r_i + 1'b1;
            default:          rd_age = '0;
        endcase
        ns      = SW'(r_newest);
        ag      = SW'(rd_age);
        rd_addr = AW'((ns >= ag) ? (ns - ag) : (ns + SW'(MAX_POINTS) - ag));
        cnt_inc = {1'b0, r_count} + 1'b1;
        cnt_next = (cnt_inc > {1'b0, maxe}) ? maxe : cnt_inc[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == prs_pkg::OP_PUSH) begin
            mem[newest_inc] <= {i_point_y, i_point_x};
        end
        if (i_cmd.rd != prs_pkg::RD_NONE) begin
            r_rd <= mem[rd_addr];
        end
    end

    // segment arithmetic
    logic [32:0] dx, dy, m, lim, tx, ty;
    logic [5:0]  ta;
    logic [4:0]  sh;
    logic [64:0] sq_diff;
    logic [63:0] sq_t;
    logic [55:0] nxs, nys;
    logic        gx, gy, ga;

    always_comb begin
        if (r_i == '0) begin
            dx = {r_nbr_x[31], r_nbr_x} - {r_cur_x[31], r_cur_x};
            dy = {r_nbr_y[31], r_nbr_y} - {r_cur_y[31], r_cur_y};
        end else begin
            dx = {r_cur_x[31], r_cur_x} - {r_prev_x[31], r_prev_x};
            dy = {r_cur_y[31], r_cur_y} - {r_prev_y[31], r_prev_y};
        end
        m       = (r_ax > r_ay) ? r_ax : r_ay;
        sh      = 5'(5'd16 >> (i_cmd.step - 5'd1));
        lim     = 33'd1 << (6'd31 - {1'b0, sh});
        sq_t    = r_root + r_bit;
        sq_diff = {1'b0, r_v} - {1'b0, sq_t};
        nxs     = {1'b0, r_nx} + {25'h0, r_root[31:1]};
        nys     = {1'b0, r_ny} + {25'h0, r_root[31:1]};
        tx      = {r_remx, r_qx[25]};
        ty      = {r_remy, r_qy[25]};
        ta      = {r_rema, r_qa[25]};
        gx      = tx >= {1'b0, r_root[31:0]};
        gy      = ty >= {1'b0, r_root[31:0]};
        ga      = ta >= {1'b0, fade5};
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            prs_pkg::OP_CAP_CUR: begin
                r_cur_x <= r_rd[31:0];
                r_cur_y <= r_rd[63:32];
            end
            prs_pkg::OP_CAP_NBR: begin
                r_nbr_x <= r_rd[31:0];
                r_nbr_y <= r_rd[63:32];
            end
            prs_pkg::OP_NEXT: begin
                r_prev_x <= r_cur_x;
                r_prev_y <= r_cur_y;
            end
            prs_pkg::OP_DIFF: begin
                r_ax  <= dx[32] ? (~dx + 33'd1) : dx;
                r_ay  <= dy[32] ? (~dy + 33'd1) : dy;
                r_dxp <= !dx[32] && (dx != '0);
                r_dyp <= !dy[32] && (dy != '0);
            end
            prs_pkg::OP_NORM: begin
                if (i_cmd.step == '0) begin
                    if (m[32]) begin
                        r_ax <= r_ax >> 2;
                        r_ay <= r_ay >> 2;
                    end else if (m[31]) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end
                    if (m == '0) begin
                        r_root <= 64'd1;
                    end
                end else if (m < lim) begin
                    r_ax <= r_ax << sh;
                    r_ay <= r_ay << sh;
                end
            end
            prs_pkg::OP_SQ: begin
                r_sqx <= r_ax[30:0] * r_ax[30:0];
                r_sqy <= r_ay[30:0] * r_ay[30:0];
            end
            prs_pkg::OP_SUM: begin
                r_v    <= {2'b00, r_sqx} + {2'b00, r_sqy};
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end
            prs_pkg::OP_SQRT: begin
                if (!sq_diff[64]) begin
                    r_v    <= sq_diff[63:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            prs_pkg::OP_MUL: begin
                r_nx <= {r_half, 8'h00} * r_ay[30:0];
                r_ny <= {r_half, 8'h00} * r_ax[30:0];
            end
            prs_pkg::OP_DIVLD: begin
                r_remx <= {2'b00, nxs[55:26]};
                r_qx   <= nxs[25:0];
                r_remy <= {2'b00, nys[55:26]};
                r_qy   <= nys[25:0];
                r_rema <= '0;
                r_qa   <= {12'h000, anum};
            end
            prs_pkg::OP_DIV: begin
                r_remx <= gx ? 32'(tx - {1'b0, r_root[31:0]}) : tx[31:0];
                r_qx   <= {r_qx[24:0], gx};
                r_remy <= gy ? 32'(ty - {1'b0, r_root[31:0]}) : ty[31:0];
                r_qy   <= {r_qy[24:0], gy};
                r_rema <= ga ? 5'(ta - {1'b0, fade5}) : ta[4:0];
                r_qa   <= {r_qa[24:0], ga};
            end
            default: ;
        endcase
    end

    // vertex assembly
    function automatic logic [31:0] sat34(input logic [33:0] v);
        logic [31:0] res;
        if (v[33] && v[32:31] != 2'b11) begin
            res = 32'h8000_0000;
        end else if (!v[33] && v[32:31] != 2'b00) begin
            res = 32'h7FFF_FFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic [33:0] ox, oy, x34, y34, vx34, vy34;
    logic        out_acc;

    always_comb begin
        ox   = r_dyp ? (34'd0 - {8'h00, r_qx}) : {8'h00, r_qx};
        oy   = r_dxp ? {8'h00, r_qy} : (34'd0 - {8'h00, r_qy});
        x34  = {{2{r_cur_x[31]}}, r_cur_x};
        y34  = {{2{r_cur_y[31]}}, r_cur_y};
        vx34 = i_cmd.side ? (x34 - ox) : (x34 + ox);
        vy34 = i_cmd.side ? (y34 - oy) : (y34 + oy);
        out_acc = r_ovalid && !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == prs_pkg::OP_EMIT) begin
            r_vx    <= sat34(vx34);
            r_vy    <= sat34(vy34);
            r_side  <= i_cmd.side;
            r_pidx  <= 4'(r_i);
            r_alpha <= faded ? r_qa[7:0] : r_base_alpha;
            r_last  <= i_cmd.side && ({1'b0, r_i} + 1'b1 == {1'b0, r_count});
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_points  <= 5'd16;
            r_half        <= 16'd128;
            r_fade_points <= 5'd4;
            r_base_alpha  <= 8'd255;
            r_newest      <= '0;
            r_count       <= '0;
            r_i           <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    prs_pkg::REG_MAX_POINTS:     r_max_points  <= i_cfg_data[4:0];
                    prs_pkg::REG_HALF_THICKNESS: r_half        <= i_cfg_data;
                    prs_pkg::REG_FADE_POINTS:    r_fade_points <= i_cfg_data[4:0];
                    prs_pkg::REG_BASE_ALPHA:     r_base_alpha  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                prs_pkg::OP_PUSH: begin
                    r_newest <= newest_inc;
                    r_count  <= cnt_next;
                end
                prs_pkg::OP_CLEAR: begin
                    r_newest <= '0;
                    r_count  <= '0;
                end
                prs_pkg::OP_INIT: r_i <= '0;
                prs_pkg::OP_NEXT: r_i <= r_i + 1'b1;
                default: ;
            endcase
            if (i_cmd.op == prs_pkg::OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.m_zero   = (r_ax == '0) && (r_ay == '0);
    assign o_stat.few      = (r_count < CW'(2));
    assign o_stat.last_pt  = ({1'b0, r_i} + 1'b1 == {1'b0, r_count});
    assign o_stat.out_free = !r_ovalid || !i_out_stall;

    assign o_out_valid   = r_ovalid;
    assign o_vertex_x    = r_vx;
    assign o_vertex_y    = r_vy;
    assign o_side        = r_side;
    assign o_point_index = r_pidx;
    assign o_alpha       = r_alpha;
    assign o_last        = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("history count above depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == prs_pkg::OP_CLEAR |=> (r_count == '0 && r_newest == '0))
        else $error("clear left points behind");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == prs_pkg::OP_PUSH |=> r_count != '0)
        else $error("push did not add a point");

    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == prs_pkg::OP_MUL |-> r_root[63:32] == '0)
        else $error("segment length too wide");

endmodule

/* hdl/polyline_ribbon_strip_generator_core.sv */
// A push walks each of the n held points (n >= 2) through the steps below, waiting on output stalls;
// a clear, or a push that leaves fewer than two points, produces no beat.
// Per point: 1 diff, up to 6 normalize, 2 square/sum, 32 root steps, 1 multiply, 1 divide
// load + 26 divide steps (one quotient bit per cycle), 2 output beats, 1 advance, 1-2 reads.
// One item at a time; the root and divide loops set the throughput.
// Synchronous active-low reset empties the history and loads the register defaults.
module polyline_ribbon_strip_generator_core #(
    parameter int MAX_POINTS = prs_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_vertex_x,
    output logic signed [31:0] o_vertex_y,
    output logic               o_side,
    output logic [3:0]         o_point_index,
    output logic [7:0]         o_alpha,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    prs_pkg::t_cmd  cmd;
    prs_pkg::t_stat stat;

    prs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    prs_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_vertex_x    (o_vertex_x),
        .o_vertex_y    (o_vertex_y),
        .o_side        (o_side),
        .o_point_index (o_point_index),
        .o_alpha       (o_alpha),
        .o_last        (o_last)
    );

endmodule

/* sim/tb_polyline_ribbon_strip_generator_core.sv */
// Testbench for the polyline ribbon strip generator: predicts every strip vertex per push.
`timescale 1ns / 100ps

class strip_scoreboard;
    logic signed [31:0] hist_x [16];
    logic signed [31:0] hist_y [16];
    int unsigned newest;
    int unsigned count;
    int unsigned max_pts;
    logic [15:0] half_th;
    int unsigned fade_pts;
    logic [7:0]  base_a;
    logic signed [31:0] q_x [$];
    logic signed [31:0] q_y [$];
    logic        q_side [$];
    logic [3:0]  q_idx [$];
    logic [7:0]  q_alpha [$];
    logic        q_last [$];
    int errors;
    int vertices;

    function new();
        newest = 0;
        count = 0;
        max_pts = 16;
        half_th = 128;
        fade_pts = 4;
        base_a = 255;
        errors = 0;
        vertices = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            prs_pkg::REG_MAX_POINTS:     max_pts = val[4:0];
            prs_pkg::REG_HALF_THICKNESS: half_th = val;
            prs_pkg::REG_FADE_POINTS:    fade_pts = val[4:0];
            default:                     base_a = val[7:0];
        endcase
    endfunction

    function longint age_x(int unsigned age);
        return hist_x[(newest + 16 - age) % 16];
    endfunction

    function longint age_y(int unsigned age);
        return hist_y[(newest + 16 - age) % 16];
    endfunction

    function longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function void perp_offset(longint dx, longint dy, output longint ox, output longint oy);
        longint unsigned ax, ay, m, h, l, mx, my;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        m = ax > ay ? ax : ay;
        h = half_th * 256;
        ox = 0;
        oy = 0;
        if (m == 0) return;
        while (m >= (64'd1 << 31)) begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        l = int_root(ax * ax + ay * ay);
        mx = (h * ay + l / 2) / l;
        my = (h * ax + l / 2) / l;
        ox = dy > 0 ? -longint'(mx) : longint'(mx);
        oy = dx > 0 ? longint'(my) : -longint'(my);
    endfunction

    function void push_expect(logic signed [31:0] x, logic signed [31:0] y, logic [3:0] idx,
                              logic [7:0] a, logic sd, logic lst);
        q_x.push_back(x); q_y.push_back(y); q_side.push_back(sd);
        q_idx.push_back(idx); q_alpha.push_back(a); q_last.push_back(lst);
    endfunction

    function void note_input(logic opc, logic signed [31:0] x, logic signed [31:0] y);
        int unsigned maxe, fade, start;
        longint cx, cy, dx, dy, ox, oy;
        logic [7:0] a;
        if (opc == prs_pkg::OPC_CLEAR) begin
            count = 0;
            newest = 0;
            return;
        end
        maxe = max_pts < 2 ? 2 : (max_pts > 16 ? 16 : max_pts);
        newest = (newest + 1) % 16;
        hist_x[newest] = x;
        hist_y[newest] = y;
        count = count + 1 > maxe ? maxe : count + 1;
        if (count < 2) return;
        fade = fade_pts > maxe ? maxe : fade_pts;
        start = maxe - fade;
        for (int unsigned i = 0; i < count; i++) begin
            cx = age_x(i);
            cy = age_y(i);
            a = base_a;
            if (fade != 0 && i >= start) a = (255 * (fade - (i - start))) / fade;
            if (i == 0) begin
                dx = age_x(1) - cx; dy = age_y(1) - cy;
            end else begin
                dx = cx - age_x(i - 1); dy = cy - age_y(i - 1);
            end
            perp_offset(dx, dy, ox, oy);
            push_expect(clip32(cx + ox), clip32(cy + oy), i[3:0], a, 1'b0, 1'b0);
            push_expect(clip32(cx - ox), clip32(cy - oy), i[3:0], a, 1'b1, i + 1 == count);
        end
    endfunction

    function void check_vertex(logic signed [31:0] x, logic signed [31:0] y, logic sd,
                               logic [3:0] idx, logic [7:0] a, logic lst);
        vertices++;
        if (q_x.size() == 0) begin
            $error("vertex beat with nothing expected");
            errors++;
            return;
        end
        if (x !== q_x[0]) begin $error("vertex_x exp %h got %h", q_x[0], x); errors++; end
        if (y !== q_y[0]) begin $error("vertex_y exp %h got %h", q_y[0], y); errors++; end
        if (sd !== q_side[0]) begin $error("side exp %b got %b", q_side[0], sd); errors++; end
        if (idx !== q_idx[0]) begin
            $error("point_index exp %0d got %0d", q_idx[0], idx); errors++;
        end
        if (a !== q_alpha[0]) begin $error("alpha exp %0d got %0d", q_alpha[0], a); errors++; end
        if (lst !== q_last[0]) begin $error("last exp %b got %b", q_last[0], lst); errors++; end
        void'(q_x.pop_front()); void'(q_y.pop_front()); void'(q_side.pop_front());
        void'(q_idx.pop_front()); void'(q_alpha.pop_front()); void'(q_last.pop_front());
    endfunction
endclass

module tb_polyline_ribbon_strip_generator_core;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_opcode;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_vertex_x;
    logic signed [31:0] o_vertex_y;
    logic               o_side;
    logic [3:0]         o_point_index;
    logic [7:0]         o_alpha;
    logic               o_last;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    strip_scoreboard sb;
    int  cycles;
    bit  idle_on;
    bit  hold_long;
    int  pushes;

    polyline_ribbon_strip_generator_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold-off
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_out_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_long = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(posedge i_clk);
                @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_vertex(o_vertex_x, o_vertex_y, o_side, o_point_index, o_alpha, o_last);
    end

    task automatic send_beat(logic opc, logic signed [31:0] x, logic signed [31:0] y);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= opc;
        i_point_x <= x;
        i_point_y <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(opc, x, y);
        if (opc == prs_pkg::OPC_PUSH) pushes++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.q_x.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
        endcase
    endfunction

    initial begin
        int mode;
        sb = new();
        cycles = 0;
        pushes = 0;
        idle_on = 1'b0;
        hold_long = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = prs_pkg::OPC_PUSH;
        i_point_x = '0;
        i_point_y = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = prs_pkg::REG_MAX_POINTS;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero-length segments, clear, saturation
        send_beat(prs_pkg::OPC_PUSH, 32'sh00010000, 32'sh00020000);
        send_beat(prs_pkg::OPC_PUSH, 32'sh00010000, 32'sh00020000);
        send_beat(prs_pkg::OPC_PUSH, 32'sh7fffffff, 32'sh80000000);
        send_beat(prs_pkg::OPC_PUSH, 32'sh80000000, 32'sh7fffffff);
        send_beat(prs_pkg::OPC_PUSH, 32'sh00000000, 32'sh00000000);
        send_beat(prs_pkg::OPC_PUSH, -32'sh00050000, 32'sh00000000);
        send_beat(prs_pkg::OPC_PUSH, -32'sh00050000, 32'sh00030000);
        send_beat(prs_pkg::OPC_CLEAR, 32'shffffffff, 32'shffffffff);
        send_beat(prs_pkg::OPC_PUSH, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(prs_pkg::OPC_PUSH, 32'sh80000000, 32'sh80000000);
        drain();
        write_reg(prs_pkg::REG_HALF_THICKNESS, 16'hffff);
        write_reg(prs_pkg::REG_MAX_POINTS, 16'd0);
        write_reg(prs_pkg::REG_FADE_POINTS, 16'd0);
        write_reg(prs_pkg::REG_BASE_ALPHA, 16'd0);
        send_beat(prs_pkg::OPC_PUSH, 32'sh7fff0000, 32'sh00000001);
        send_beat(prs_pkg::OPC_PUSH, 32'sh7ffffff0, -32'sh00000001);
        send_beat(prs_pkg::OPC_PUSH, 32'sh00000003, 32'sh00000005);
        drain();
        write_reg(prs_pkg::REG_MAX_POINTS, 16'd31);
        write_reg(prs_pkg::REG_FADE_POINTS, 16'd31);
        write_reg(prs_pkg::REG_HALF_THICKNESS, 16'd0);
        write_reg(prs_pkg::REG_BASE_ALPHA, 16'd200);
        for (int i = 0; i < 6; i++) send_beat(prs_pkg::OPC_PUSH, rand_coord(2), rand_coord(2));

        // random phases, each with its own register setting
        idle_on = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(prs_pkg::REG_MAX_POINTS,
                      ph == 0 ? 16'd16 : 16'($urandom_range(0, 31)));
            write_reg(prs_pkg::REG_HALF_THICKNESS, ph == 1 ? 16'd0 : 16'($urandom));
            write_reg(prs_pkg::REG_FADE_POINTS, 16'($urandom_range(0, 31)));
            write_reg(prs_pkg::REG_BASE_ALPHA, 16'($urandom_range(0, 255)));
            if (ph == 2) hold_long = 1'b1;
            if (ph == 5) idle_on = 1'b0;
            mode = ph % 3;
            for (int i = 0; i < 17; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(prs_pkg::OPC_CLEAR, $urandom, $urandom);
                else
                    send_beat(prs_pkg::OPC_PUSH,
                              rand_coord($urandom_range(0, 5) == 0 ? 0 : mode),
                              rand_coord($urandom_range(0, 5) == 0 ? 0 : mode));
            end
        end
        drain();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d pushes and %0d vertex beats over several register settings,",
                 pushes, sb.vertices);
        $display("including clamped depth, zero thickness, saturation and a long output hold.");
        if (sb.errors == 0 && sb.q_x.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* files.f */
hdl/prs_pkg.sv
hdl/prs_ctrl.sv
hdl/prs_dpath.sv
hdl/polyline_ribbon_strip_generator_core.sv
sim/tb_polyline_ribbon_strip_generator_core.sv
